[src/spp_pkg.sv]
// Shared constants, types and register codes for the scope trace pixel plotter.
package spp_pkg;

   // Design limits
   localparam int MAX_COLUMNS    = 320;
   localparam int ADC_FULL_SCALE = 4095;

   // Field widths
   localparam int SAMPLE_W   = 12;
   localparam int COORD_W    = 9;
   localparam int CHAN_SEL_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Row store addressing; fill count must hold MAX_COLUMNS itself
   localparam int ADDR_W = $clog2(MAX_COLUMNS);
   localparam int FILL_W = ADDR_W + 1;

   // Scaling datapath: p = sample*height, p/full_scale by reciprocal multiply
   localparam int PROD_W      = SAMPLE_W + COORD_W;
   localparam int RECIP_SHIFT = 32;
   localparam int MUL_W       = RECIP_SHIFT + COORD_W;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / ADC_FULL_SCALE;

   // Register reset values
   localparam logic [COORD_W-1:0]    WIDTH_RST  = 9'd320;
   localparam logic [COORD_W-1:0]    HEIGHT_RST = 9'd240;
   localparam logic [COORD_W-1:0]    SKIP_RST   = 9'd1;
   localparam logic [CHAN_SEL_W-1:0] CHAN_FIRST  = 2'd1;
   localparam logic [CHAN_SEL_W-1:0] CHAN_SECOND = 2'd2;

   // Register map, one word per register
   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH,
      REG_SCREEN_HEIGHT,
      REG_SKIP_INTERVAL,
      REG_DISPLAYED_CHANNEL
   } csr_reg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                channel;
      logic                buffer_last;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               plot;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0]    screen_width;
      logic [COORD_W-1:0]    screen_height;
      logic [COORD_W-1:0]    skip_interval;
      logic [CHAN_SEL_W-1:0] displayed_channel;
   } cfg_type;

   // Scaled pixel leaving the arithmetic pipeline
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } cmd_type;

endpackage

[src/spp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module spp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read and a write of one address in a cycle return the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/spp_csr.sv]
// APB-style configuration registers of the plotter.
module spp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [spp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [spp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [spp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output spp_pkg::cfg_type                 cfg
);

   spp_pkg::cfg_type     cfg_ff;
   spp_pkg::cfg_type     cfg_in;
   spp_pkg::csr_reg_type reg_sel;
   logic                 wr_xfer;

   assign reg_sel = spp_pkg::csr_reg_type'(paddr[3:2]);
   assign wr_xfer = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_xfer) begin
         unique case (reg_sel)
            spp_pkg::REG_SCREEN_WIDTH:
               cfg_in.screen_width = pwdata[spp_pkg::COORD_W-1:0];
            spp_pkg::REG_SCREEN_HEIGHT:
               cfg_in.screen_height = pwdata[spp_pkg::COORD_W-1:0];
            spp_pkg::REG_SKIP_INTERVAL:
               cfg_in.skip_interval = pwdata[spp_pkg::COORD_W-1:0];
            spp_pkg::REG_DISPLAYED_CHANNEL:
               cfg_in.displayed_channel = pwdata[spp_pkg::CHAN_SEL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width      <= spp_pkg::WIDTH_RST;
         cfg_ff.screen_height     <= spp_pkg::HEIGHT_RST;
         cfg_ff.skip_interval     <= spp_pkg::SKIP_RST;
         cfg_ff.displayed_channel <= spp_pkg::CHAN_FIRST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         spp_pkg::REG_SCREEN_WIDTH:
            prdata = spp_pkg::CSR_DATA_W'(cfg_ff.screen_width);
         spp_pkg::REG_SCREEN_HEIGHT:
            prdata = spp_pkg::CSR_DATA_W'(cfg_ff.screen_height);
         spp_pkg::REG_SKIP_INTERVAL:
            prdata = spp_pkg::CSR_DATA_W'(cfg_ff.skip_interval);
         spp_pkg::REG_DISPLAYED_CHANNEL:
            prdata = spp_pkg::CSR_DATA_W'(cfg_ff.displayed_channel);
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[src/spp_colseq.sv]
// Column sequencer: channel select, skip handling, column and phase counters.
module spp_colseq (
   input  logic                         clock,
   input  logic                         reset,
   input  spp_pkg::cfg_type             cfg,
   input  logic                         take,
   input  logic                         channel,
   output logic                         keep,
   output logic [spp_pkg::COORD_W-1:0]  column
);

   logic [spp_pkg::COORD_W-1:0] col_ff, col_in;
   logic [spp_pkg::COORD_W-1:0] phase_ff, phase_in;
   logic                        pending_ff, pending_in;
   logic                        shown;
   logic                        drop_now;
   logic [spp_pkg::COORD_W:0]   col_next;
   logic [spp_pkg::COORD_W-1:0] phase_inc;
   logic                        wrap;

   always_comb begin
      // Only the selected channel counts; selector codes 0 and 3 show nothing
      shown = ((cfg.displayed_channel == spp_pkg::CHAN_FIRST) && !channel) ||
              ((cfg.displayed_channel == spp_pkg::CHAN_SECOND) && channel);
      drop_now  = (phase_ff == '0) && !pending_ff;
      keep      = shown && !drop_now;
      col_next  = {1'b0, col_ff} + 1'b1;
      phase_inc = phase_ff + 1'b1;
      // Wrap at the smaller of screen width and store depth
      wrap = (col_next >= {1'b0, cfg.screen_width}) ||
             (32'(col_next) >= 32'(spp_pkg::MAX_COLUMNS));

      col_in     = col_ff;
      phase_in   = phase_ff;
      pending_in = pending_ff;
      if (take && shown) begin
         if (drop_now) begin
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            if (wrap) begin
               col_in   = '0;
               phase_in = '0;
            end else begin
               col_in   = col_next[spp_pkg::COORD_W-1:0];
               phase_in = (phase_inc >= cfg.skip_interval) ? '0 : phase_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         phase_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

   assign column = col_ff;

   // Column always addresses a row store entry
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(spp_pkg::MAX_COLUMNS))
      else $error("column counter beyond row store");

endmodule

[src/spp_scale.sv]
// Three-stage elastic pipeline: row = height - sample*height/full_scale.
module spp_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [spp_pkg::COORD_W-1:0]   height,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [spp_pkg::SAMPLE_W-1:0]  in_sample,
   input  logic [spp_pkg::COORD_W-1:0]   in_column,
   output logic                          out_valid,
   input  logic                          out_ready,
   output spp_pkg::cmd_type              out_cmd
);

   logic a_vld_ff, a_vld_in, b_vld_ff, b_vld_in, c_vld_ff, c_vld_in;
   logic a_free, b_free, c_free;

   logic [spp_pkg::PROD_W-1:0]   a_p_ff;
   logic [spp_pkg::COORD_W-1:0]  a_col_ff;
   logic [spp_pkg::MUL_W-1:0]    b_m_ff;
   logic [spp_pkg::PROD_W-1:0]   b_p_ff;
   logic [spp_pkg::COORD_W-1:0]  b_col_ff;
   logic [spp_pkg::COORD_W-1:0]  c_q_ff;
   logic [spp_pkg::PROD_W-1:0]   c_qfs_ff;
   logic [spp_pkg::PROD_W-1:0]   c_p_ff;
   logic [spp_pkg::COORD_W-1:0]  c_col_ff;

   logic [spp_pkg::SAMPLE_W-1:0] sample_sat;
   logic [spp_pkg::COORD_W-1:0]  q_est;
   logic [spp_pkg::PROD_W-1:0]   rem;
   logic                         corr;

   // Stage occupancy; a stage frees when empty or when it moves on
   always_comb begin
      c_free   = !c_vld_ff || out_ready;
      b_free   = !b_vld_ff || c_free;
      a_free   = !a_vld_ff || b_free;
      a_vld_in = a_free ? in_valid : a_vld_ff;
      b_vld_in = b_free ? a_vld_ff : b_vld_ff;
      c_vld_in = c_free ? b_vld_ff : c_vld_ff;
   end

   assign in_ready  = a_free;
   assign out_valid = c_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
      end
   end

   // Saturate above full scale, then the quotient estimate from the reciprocal product
   always_comb begin
      sample_sat = (32'(in_sample) > 32'(spp_pkg::ADC_FULL_SCALE)) ?
                   spp_pkg::SAMPLE_W'(spp_pkg::ADC_FULL_SCALE) : in_sample;
      q_est      = b_m_ff[spp_pkg::RECIP_SHIFT +: spp_pkg::COORD_W];
   end

   // Stage A: sample*height; B: times reciprocal; C: estimate times full scale
   always_ff @(posedge clock) begin
      if (a_free) begin
         a_p_ff   <= spp_pkg::PROD_W'(sample_sat) * spp_pkg::PROD_W'(height);
         a_col_ff <= in_column;
      end
      if (b_free) begin
         b_m_ff   <= spp_pkg::MUL_W'(a_p_ff) * spp_pkg::MUL_W'(spp_pkg::RECIP);
         b_p_ff   <= a_p_ff;
         b_col_ff <= a_col_ff;
      end
      if (c_free) begin
         c_q_ff   <= q_est;
         c_qfs_ff <= spp_pkg::PROD_W'(q_est) * spp_pkg::PROD_W'(spp_pkg::ADC_FULL_SCALE);
         c_p_ff   <= b_p_ff;
         c_col_ff <= b_col_ff;
      end
   end

   // Estimate is low by at most one: a single compare corrects it
   always_comb begin
      rem            = c_p_ff - c_qfs_ff;
      corr           = rem >= spp_pkg::PROD_W'(spp_pkg::ADC_FULL_SCALE);
      out_cmd.column = c_col_ff;
      out_cmd.row    = height - c_q_ff - spp_pkg::COORD_W'(corr);
   end

endmodule

[src/scope_trace_pixel_plotter.sv]
// Top level of the scope trace pixel plotter: channel intake, row store and pixel output.
//
// Each plotted sample yields two pixel transfers on the rsp channel, an erase of
// the row last drawn in its column and then a plot of the new row; the output
// stage that sends both commands takes no new pixel until the plot of the last
// one transfers. Samples of the other channel and dropped samples are taken
// whenever the first arithmetic stage has room. A plotted sample passes through
// the three arithmetic stages, the last of which loads the output stage, before
// the erase is offered, and the plot follows the erase. The row store is a RAM
// read and written once per plotted sample as the pixel enters the output
// stage; a fill count marks columns not yet drawn since reset, which erase
// row 0, so no clearing pass is needed and samples are taken right after reset.
module scope_trace_pixel_plotter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  spp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output spp_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [spp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [spp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [spp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   spp_pkg::cfg_type            cfg;
   spp_pkg::cmd_type            cmd;
   logic                        take;
   logic                        keep;
   logic [spp_pkg::COORD_W-1:0] seq_col;
   logic                        cmd_valid;

   logic                        o_vld_ff, o_vld_in;
   logic                        o_plot_ff, o_plot_in;
   logic [spp_pkg::COORD_W-1:0] o_col_ff;
   logic [spp_pkg::COORD_W-1:0] o_row_ff;
   logic                        o_old_ok_ff;
   logic [spp_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic                        o_free;
   logic                        o_load;
   logic                        rsp_xfer;
   logic [spp_pkg::ADDR_W-1:0]  store_addr;
   logic [spp_pkg::COORD_W-1:0] old_row;

   spp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign take = req_valid && req_ready;

   spp_colseq u_colseq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .take    (take),
      .channel (req_data.channel),
      .keep    (keep),
      .column  (seq_col)
   );

   spp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .height    (cfg.screen_height),
      .in_valid  (req_valid && keep),
      .in_ready  (req_ready),
      .in_sample (req_data.sample),
      .in_column (seq_col),
      .out_valid (cmd_valid),
      .out_ready (o_free),
      .out_cmd   (cmd)
   );

   // Output stage: holds one pixel pair, erase first then plot
   always_comb begin
      rsp_xfer   = rsp_valid && rsp_ready;
      o_free     = !o_vld_ff || (rsp_ready && o_plot_ff);
      o_load     = cmd_valid && o_free;
      store_addr = spp_pkg::ADDR_W'(cmd.column);

      o_vld_in  = o_vld_ff;
      o_plot_in = o_plot_ff;
      if (o_load) begin
         o_vld_in  = 1'b1;
         o_plot_in = 1'b0;
      end else if (rsp_xfer) begin
         if (o_plot_ff) begin
            o_vld_in = 1'b0;
         end else begin
            o_plot_in = 1'b1;
         end
      end

      // Columns are drawn in order from zero, so the written set is a prefix
      fill_in = fill_ff;
      if (o_load && ({1'b0, store_addr} == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff  <= 1'b0;
         o_plot_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         o_vld_ff  <= o_vld_in;
         o_plot_ff <= o_plot_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_col_ff    <= cmd.column;
         o_row_ff    <= cmd.row;
         o_old_ok_ff <= {1'b0, store_addr} < fill_ff;
      end
   end

   // Row store: read-first, so the old row comes back in the cycle the new one lands
   spp_ram #(
      .WIDTH (spp_pkg::COORD_W),
      .DEPTH (spp_pkg::MAX_COLUMNS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (o_load),
      .wr_addr (store_addr),
      .wr_data (cmd.row),
      .rd_en   (o_load),
      .rd_addr (store_addr),
      .rd_data (old_row)
   );

   // Result fields
   always_comb begin
      rsp_valid       = o_vld_ff;
      rsp_data.column = o_col_ff;
      rsp_data.row    = o_plot_ff ? o_row_ff : (o_old_ok_ff ? old_row : '0);
      rsp_data.plot   = o_plot_ff;
      rsp_data.last   = o_plot_ff;
   end

   // An erase transfer is followed by the plot of the same column
   a_erase_then_plot: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_data.plot) |=>
         (rsp_valid && rsp_data.plot && (rsp_data.column == $past(rsp_data.column))))
      else $error("erase not followed by plot of same column");

   // Fill count never passes the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(spp_pkg::MAX_COLUMNS))
      else $error("fill count beyond row store depth");

   // A plotted row never lies below the screen height
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.plot) |-> (rsp_data.row <= cfg.screen_height))
      else $error("plotted row beyond screen height");

endmodule

[bench/scope_trace_pixel_plotter_checker.sv]
// Checker for the scope trace pixel plotter: mirrors its state and compares pixel transfers.
module scope_trace_pixel_plotter_checker
   import spp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    pending_pixels
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the registers
   logic [COORD_W-1:0]    width_cfg;
   logic [COORD_W-1:0]    height_cfg;
   logic [COORD_W-1:0]    skip_cfg;
   logic [CHAN_SEL_W-1:0] channel_cfg;

   // Shadow copy of the trace state
   logic [COORD_W-1:0]    trace_column;
   logic [COORD_W-1:0]    column_phase;
   logic                  drop_done;
   logic [COORD_W-1:0]    drawn_rows [MAX_COLUMNS];

   rsp_type               expected_pixels [$];
   int                    errors = 0;
   int                    queued = 0;

   assign mismatch_count = errors;
   assign pending_pixels = queued;

   task automatic report_mismatch(input string what, input int got, input int want);
      // cap the log; every mismatch is still counted
      if (errors < 40) begin
         $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      errors++;
   endtask

   // Works out the erase/plot pair caused by one sample, if any
   task automatic predict_pixels(input req_type item);
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      int unsigned        sat;
      int unsigned        scaled;
      int unsigned        limit;
      int unsigned        next_col;
      if (channel_cfg != CHAN_FIRST && channel_cfg != CHAN_SECOND) return;
      if (item.channel != (channel_cfg == CHAN_SECOND)) return;
      // a phase-zero column drops one sample before drawing
      if (column_phase == '0 && !drop_done) begin
         drop_done = 1'b1;
         return;
      end
      col = (trace_column >= MAX_COLUMNS) ? '0 : trace_column;
      sat = (item.sample > ADC_FULL_SCALE) ? ADC_FULL_SCALE : item.sample;
      scaled = height_cfg - (sat * height_cfg) / ADC_FULL_SCALE;
      row = scaled[COORD_W-1:0];
      expected_pixels.push_back('{column: col, row: drawn_rows[col], plot: 1'b0, last: 1'b0});
      expected_pixels.push_back('{column: col, row: row, plot: 1'b1, last: 1'b1});
      drawn_rows[col] = row;
      // advance the column, wrapping at the usable width
      limit = (width_cfg > MAX_COLUMNS) ? MAX_COLUMNS : width_cfg;
      next_col = col + 1;
      if (next_col >= limit) begin
         trace_column = '0;
         column_phase = '0;
      end else begin
         trace_column = next_col[COORD_W-1:0];
         column_phase = column_phase + 1'b1;
         if (column_phase >= skip_cfg) column_phase = '0;
      end
      drop_done = 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         width_cfg    = WIDTH_RST;
         height_cfg   = HEIGHT_RST;
         skip_cfg     = SKIP_RST;
         channel_cfg  = CHAN_FIRST;
         trace_column = '0;
         column_phase = '0;
         drop_done    = 1'b0;
         foreach (drawn_rows[i]) drawn_rows[i] = '0;
         expected_pixels.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (csr_reg_type'(paddr[3:2]))
               REG_SCREEN_WIDTH:      width_cfg   = pwdata[COORD_W-1:0];
               REG_SCREEN_HEIGHT:     height_cfg  = pwdata[COORD_W-1:0];
               REG_SKIP_INTERVAL:     skip_cfg    = pwdata[COORD_W-1:0];
               REG_DISPLAYED_CHANNEL: channel_cfg = pwdata[CHAN_SEL_W-1:0];
            endcase
         end
         // compare pixel transfers against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("pixel transfer with none expected, column",
                               rsp_data.column, -1);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.column != want.column)
                  report_mismatch("column", rsp_data.column, want.column);
               if (rsp_data.row != want.row)
                  report_mismatch("row", rsp_data.row, want.row);
               if (rsp_data.plot != want.plot)
                  report_mismatch("plot", rsp_data.plot, want.plot);
               if (rsp_data.last != want.last)
                  report_mismatch("last", rsp_data.last, want.last);
            end
         end
         if (req_valid && req_ready) predict_pixels(req_data);
      end
      queued <= expected_pixels.size();
   end

endmodule

[bench/scope_trace_pixel_plotter_tb.sv]
// Testbench top for the scope trace pixel plotter: clock, reset, stimulus and verdict.
module scope_trace_pixel_plotter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spp_pkg::*;

   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int NUM_PHASES    = 12;
   localparam int SHOWN_QUOTA   = 60;
   localparam int IGNORED_QUOTA = 30;

   // selector codes that display no channel
   localparam logic [CHAN_SEL_W-1:0] CHAN_OFF_LOW  = 2'd0;
   localparam logic [CHAN_SEL_W-1:0] CHAN_OFF_HIGH = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    pending_pixels;
   int                    rsp_transfers = 0;
   int                    send_quiet    = 0;
   logic                  req_fire;
   logic                  rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   scope_trace_pixel_plotter DUT (.*);

   scope_trace_pixel_plotter_checker pixel_check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_fire) rsp_transfers <= rsp_transfers + 1;
   end

   // mostly short idle gaps, now and then a long one
   function automatic int gap_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one sample and returns at the edge where it is transferred
   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic chan,
                              input logic tail);
      int idle;
      if (send_quiet > 0) begin
         send_quiet--;
         idle = 0;
      end else begin
         idle = gap_cycles();
         if ($urandom_range(0, 39) == 0) send_quiet = $urandom_range(30, 90);
      end
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: value, channel: chan, buffer_last: tail};
      do @(posedge clock); while (!req_ready);
   endtask

   // Setup then access cycle; the bus idles ahead of each write
   task automatic write_reg(input csr_reg_type idx, input logic [COORD_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_setting(input cfg_type s);
      write_reg(REG_SCREEN_WIDTH, s.screen_width);
      write_reg(REG_SCREEN_HEIGHT, s.screen_height);
      write_reg(REG_SKIP_INTERVAL, s.skip_interval);
      write_reg(REG_DISPLAYED_CHANNEL, {{(COORD_W-CHAN_SEL_W){1'b0}}, s.displayed_channel});
   endtask

   // Wait for every expected pixel, then let the design settle
   task automatic drain();
      do @(posedge clock); while (pending_pixels != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Fixed corners first, random settings after
   function automatic cfg_type planned_setting(input int p);
      cfg_type s;
      case (p)
         0: s = '{9'd5,   9'd320, 9'd2,   CHAN_SECOND};
         1: s = '{9'd0,   9'd0,   9'd0,   CHAN_FIRST};
         2: s = '{9'd511, 9'd511, 9'd511, CHAN_SECOND};
         3: s = '{9'd1,   9'd1,   9'd320, CHAN_OFF_LOW};
         4: s = '{9'd320, 9'd240, 9'd3,   CHAN_OFF_HIGH};
         5: s = '{9'd320, 9'd240, 9'd1,   CHAN_FIRST};
         6: s = '{9'd320, 9'd100, 9'd7,   CHAN_SECOND};
         7: s = '{9'd17,  9'd64,  9'd5,   CHAN_FIRST};
         default: begin
            s.screen_width  = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                          : 9'($urandom_range(1, 48));
            s.screen_height = 9'($urandom_range(0, 511));
            s.skip_interval = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                          : 9'($urandom_range(1, 12));
            if ($urandom_range(0, 7) == 0)
               s.displayed_channel = CHAN_SEL_W'($urandom_range(0, 3));
            else
               s.displayed_channel = ($urandom_range(0, 1) == 0) ? CHAN_FIRST : CHAN_SECOND;
         end
      endcase
      return s;
   endfunction

   // Interleaved two-channel stream with occasional broken interleave
   task automatic run_phase(input cfg_type s);
      logic                shows;
      logic                shown_chan;
      logic                chan;
      logic                chan_next;
      logic [SAMPLE_W-1:0] value;
      int                  quota;
      int                  counted;
      int                  pick;
      shows      = (s.displayed_channel == CHAN_FIRST || s.displayed_channel == CHAN_SECOND);
      shown_chan = (s.displayed_channel == CHAN_SECOND);
      quota      = shows ? SHOWN_QUOTA : IGNORED_QUOTA;
      counted    = 0;
      chan_next  = 1'b0;
      while (counted < quota) begin
         chan      = ($urandom_range(0, 99) < 88) ? chan_next : 1'($urandom_range(0, 1));
         chan_next = !chan;
         pick      = $urandom_range(0, 9);
         if (pick == 0)
            value = '0;
         else if (pick == 1)
            value = '1;
         else
            value = SAMPLE_W'($urandom_range(0, 4095));
         send_sample(value, chan, $urandom_range(0, 15) == 0);
         if (!shows || chan == shown_chan) counted++;
      end
      req_valid <= 1'b0;
   endtask

   // Result side: random stalls, quiet stretches and two long hold-offs
   initial begin : sink
      int idle;
      int holds_done;
      int quiet;
      holds_done = 0;
      quiet      = 0;
      @(posedge clock);
      forever begin
         if (holds_done < 2 && req_valid && rsp_transfers >= 300 + 900 * holds_done) begin
            idle = HOLD_CYCLES;
            holds_done++;
         end else if (quiet > 0) begin
            quiet--;
            idle = 0;
         end else begin
            idle = gap_cycles();
            if ($urandom_range(0, 29) == 0) quiet = $urandom_range(20, 60);
         end
         if (idle != 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Ends the run when no transfer happens for too long
   initial begin : watchdog
      int stale;
      stale = 0;
      while (stale < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire)
            stale = 0;
         else
            stale++;
      end
      $display("scope_trace_pixel_plotter: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0] corner_values [8];
      cfg_type             setting;
      corner_values = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'hAAA, 12'h555, 12'd2047, 12'd2048};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: other-channel sample, then a dropped and a drawn one per corner value
      for (int i = 0; i < 8; i++) begin
         send_sample(corner_values[i], 1'b1, 1'b0);
         send_sample(corner_values[i], 1'b0, 1'b0);
         send_sample(corner_values[i], 1'b0, i[0]);
      end
      req_valid <= 1'b0;
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         setting = planned_setting(p);
         apply_setting(setting);
         run_phase(setting);
         drain();
      end

      if (mismatch_count == 0 && pending_pixels == 0) begin
         $display("scope_trace_pixel_plotter: match");
      end else begin
         $display("scope_trace_pixel_plotter: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
src/spp_pkg.sv
src/spp_ram.sv
src/spp_csr.sv
src/spp_colseq.sv
src/spp_scale.sv
src/scope_trace_pixel_plotter.sv
bench/scope_trace_pixel_plotter_checker.sv
bench/scope_trace_pixel_plotter_tb.sv
